// ----- design/alc_pkg.sv -----
// Package for the active lane consolidation permute.
// Holds the item types, stage types and lane constants; no dependencies.
package alc_pkg;

   localparam int LANES     = 4;
   localparam int ELEM_BITS = 32;
   localparam int IDX_BITS  = $clog2(LANES);
   localparam int CNT_BITS  = $clog2(LANES + 1);
   localparam int SUM_BITS  = CNT_BITS + 1;

   typedef logic signed [ELEM_BITS-1:0] elem_type;
   typedef logic [LANES-1:0]            lane_mask_type;
   typedef logic [IDX_BITS-1:0]         idx_type;
   typedef logic [CNT_BITS-1:0]         cnt_type;

   typedef struct packed {
      elem_type      a_lane0;
      elem_type      a_lane1;
      elem_type      a_lane2;
      elem_type      a_lane3;
      elem_type      b_lane0;
      elem_type      b_lane1;
      elem_type      b_lane2;
      elem_type      b_lane3;
      lane_mask_type mask_a;
      lane_mask_type mask_b;
   } req_type;

   typedef struct packed {
      elem_type      packed_lane0;
      elem_type      packed_lane1;
      elem_type      packed_lane2;
      elem_type      packed_lane3;
      elem_type      rest_lane0;
      elem_type      rest_lane1;
      elem_type      rest_lane2;
      elem_type      rest_lane3;
      lane_mask_type packed_mask;
      lane_mask_type rest_mask;
   } rsp_type;

   // Stage 1 result: lanes with their destination slots.
   typedef struct packed {
      elem_type [LANES-1:0] a;
      elem_type [LANES-1:0] b;
      lane_mask_type        mask_a;
      idx_type [LANES-1:0]  a_pos;
      idx_type [LANES-1:0]  b_pos;
      cnt_type              na;
      cnt_type              nb;
   } rank_type;

   // Stage 2 result: compacted lists.
   typedef struct packed {
      elem_type [LANES-1:0] a_on;
      elem_type [LANES-1:0] a_off;
      elem_type [LANES-1:0] b_seq;
      cnt_type              na;
      cnt_type              nb;
   } compact_type;

endpackage

// ----- design/active_lane_consolidation_permute.sv -----
// Active lane consolidation permute: three-stage pipeline (rank, compact, assemble).
// Each item is registered by the rank, compact and assemble stages in that order, and its result
// then shows on rsp_data with rsp_strobe.
// Throughput: one item per cycle; busy stays low, so every item is taken at once.
// Reset (synchronous, active high) clears the stage valid bits; items in flight are dropped.
// Depends on alc_pkg, alc_rank, alc_compact and alc_assemble.
module active_lane_consolidation_permute (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  alc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output alc_pkg::rsp_type rsp_data
);
   import alc_pkg::*;

   // Handshake: the receiver cannot stall, so the pipeline never backs up.
   logic        rank_valid;
   rank_type    rank_data;
   logic        comp_valid;
   compact_type comp_data;

   assign busy = 1'b0;

   // Stage 1: count active lanes of A and B and give each lane its slot.
   alc_rank u_rank (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_data   (req_data),
      .out_valid (rank_valid),
      .out_data  (rank_data)
   );

   // Stage 2: gather A actives, A inactives and the B sequence (actives, then inactives).
   alc_compact u_compact (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rank_valid),
      .in_data   (rank_data),
      .out_valid (comp_valid),
      .out_data  (comp_data)
   );

   // Stage 3: pack A actives then B actives, pad with all ones; fill the rest
   // vector with A inactives, then the B sequence by lane index.
   alc_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comp_valid),
      .in_data   (comp_data),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

// ----- design/alc_rank.sv -----
// Stage 1 of the permute: counts active lanes and ranks every lane.
// Depends on alc_pkg.
module alc_rank (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  alc_pkg::req_type  in_data,
   output logic              out_valid,
   output alc_pkg::rank_type out_data
);
   import alc_pkg::*;

   logic     valid_ff;
   rank_type rank_ff;
   rank_type rank_in;

   always_comb begin
      cnt_type below_on;
      cnt_type below_off;
      cnt_type nb;
      rank_in        = '0;
      rank_in.a      = {in_data.a_lane3, in_data.a_lane2, in_data.a_lane1, in_data.a_lane0};
      rank_in.b      = {in_data.b_lane3, in_data.b_lane2, in_data.b_lane1, in_data.b_lane0};
      rank_in.mask_a = in_data.mask_a;
      nb             = '0;
      for (int i = 0; i < LANES; i++) begin
         rank_in.na = rank_in.na + CNT_BITS'(in_data.mask_a[i]);
         nb         = nb + CNT_BITS'(in_data.mask_b[i]);
      end
      rank_in.nb = nb;
      for (int i = 0; i < LANES; i++) begin
         below_on  = '0;
         below_off = '0;
         for (int k = 0; k < i; k++) begin
            below_on  = below_on + CNT_BITS'(in_data.mask_a[k] == in_data.mask_a[i]);
            below_off = below_off + CNT_BITS'(in_data.mask_b[k] == in_data.mask_b[i]);
         end
         rank_in.a_pos[i] = IDX_BITS'(below_on);
         // inactive B lanes follow all active ones
         if (in_data.mask_b[i]) begin
            rank_in.b_pos[i] = IDX_BITS'(below_off);
         end else begin
            rank_in.b_pos[i] = IDX_BITS'(nb + below_off);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rank_ff;

endmodule

// ----- design/alc_compact.sv -----
// Stage 2 of the permute: gathers lanes into the A-active, A-inactive
// and B sequence lists. Depends on alc_pkg.
module alc_compact (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  alc_pkg::rank_type    in_data,
   output logic                 out_valid,
   output alc_pkg::compact_type out_data
);
   import alc_pkg::*;

   logic        valid_ff;
   compact_type comp_ff;
   compact_type comp_in;

   always_comb begin
      comp_in    = '0;
      comp_in.na = in_data.na;
      comp_in.nb = in_data.nb;
      for (int j = 0; j < LANES; j++) begin
         for (int i = 0; i < LANES; i++) begin
            if (in_data.a_pos[i] == IDX_BITS'(j)) begin
               if (in_data.mask_a[i]) begin
                  comp_in.a_on[j] = comp_in.a_on[j] | in_data.a[i];
               end else begin
                  comp_in.a_off[j] = comp_in.a_off[j] | in_data.a[i];
               end
            end
            if (in_data.b_pos[i] == IDX_BITS'(j)) begin
               comp_in.b_seq[j] = comp_in.b_seq[j] | in_data.b[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff <= comp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = comp_ff;

endmodule

// ----- design/alc_assemble.sv -----
// Stage 3 of the permute: builds the packed and rest vectors and masks.
// Depends on alc_pkg.
module alc_assemble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  alc_pkg::compact_type in_data,
   output logic                 out_valid,
   output alc_pkg::rsp_type     out_data
);
   import alc_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      elem_type [LANES-1:0] pk;
      elem_type [LANES-1:0] rs;
      lane_mask_type        pmask;
      lane_mask_type        rmask;
      logic [SUM_BITS-1:0]  total;
      cnt_type              noff;
      total = SUM_BITS'(in_data.na) + SUM_BITS'(in_data.nb);
      noff  = CNT_BITS'(LANES) - in_data.na;
      pmask = '0;
      rmask = '0;
      for (int i = 0; i < LANES; i++) begin
         if (CNT_BITS'(i) < in_data.na) begin
            pk[i] = in_data.a_on[i];
         end else if (SUM_BITS'(i) < total) begin
            pk[i] = in_data.b_seq[IDX_BITS'(CNT_BITS'(i) - in_data.na)];
         end else begin
            pk[i] = '1;
         end
         pmask[i] = SUM_BITS'(i) < total;
         if (CNT_BITS'(i) < noff) begin
            rs[i] = in_data.a_off[i];
         end else begin
            rs[i] = in_data.b_seq[i];
         end
         rmask[i] = (CNT_BITS'(i) >= noff) && (CNT_BITS'(i) < in_data.nb);
      end
      rsp_in.packed_lane0 = pk[0];
      rsp_in.packed_lane1 = pk[1];
      rsp_in.packed_lane2 = pk[2];
      rsp_in.packed_lane3 = pk[3];
      rsp_in.rest_lane0   = rs[0];
      rsp_in.rest_lane1   = rs[1];
      rsp_in.rest_lane2   = rs[2];
      rsp_in.rest_lane3   = rs[3];
      rsp_in.packed_mask  = pmask;
      rsp_in.rest_mask    = rmask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule
